>>> hw/rtl/point_to_line_distance_core_assert.svh
`ifndef POINT_TO_LINE_DISTANCE_CORE_ASSERT_SVH
`define POINT_TO_LINE_DISTANCE_CORE_ASSERT_SVH
// Assertion macros for the point-to-line distance core.
// Both expect clk and rst_n in scope and are silent while reset is held.

// Same-cycle implication.
`define PTLD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PTLD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/ptld_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptld_pkg
// Shared constants and the register map of the point-to-line distance core.
// ----------------------------------------------------------------------------
package ptld_pkg;

  // Default coordinate width and the fixed fraction width of all coordinates.
  localparam int unsigned COORD_BITS_DEF = 24;
  localparam int unsigned FRAC_BITS      = 8;

  // Register index width and register map.
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_AX = 2'd0,
    REG_LINE_AY = 2'd1,
    REG_LINE_BX = 2'd2,
    REG_LINE_BY = 2'd3
  } cfg_reg_t;

endpackage

>>> hw/rtl/ptld_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptld_div_cell
// One restoring division step: resolves quotient bit K of an unsigned divide.
// ----------------------------------------------------------------------------
module ptld_div_cell #(
  parameter int unsigned NW = 16,
  parameter int unsigned DW = 8,
  parameter int unsigned QW = 8,
  parameter int unsigned TW = 1,
  parameter int unsigned K  = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_rem,
  input  logic [DW-1:0] in_div,
  input  logic [QW-1:0] in_quo,
  input  logic [TW-1:0] in_tag,
  output logic          out_valid,
  output logic [NW-1:0] out_rem,
  output logic [DW-1:0] out_div,
  output logic [QW-1:0] out_quo,
  output logic [TW-1:0] out_tag
);

  localparam int unsigned CW = (DW + QW > NW) ? DW + QW : NW;

  logic [CW-1:0] rem_ext;
  logic [CW-1:0] trial;
  logic          fits;
  logic [NW-1:0] rem_nxt;
  logic [QW-1:0] quo_nxt;
  logic          valid_r;
  logic [NW-1:0] rem_r;
  logic [DW-1:0] div_r;
  logic [QW-1:0] quo_r;
  logic [TW-1:0] tag_r;

  // Compare the partial remainder with the divisor shifted to bit K.
  assign rem_ext = CW'(in_rem);
  assign trial   = CW'(in_div) << K;
  assign fits    = rem_ext >= trial;
  assign rem_nxt = fits ? NW'(rem_ext - trial) : in_rem;
  assign quo_nxt = in_quo | (QW'(fits) << K);

  // Beat valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  // Payload handed on to the next cell.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      div_r <= in_div;
      quo_r <= quo_nxt;
      tag_r <= in_tag;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_div   = div_r;
  assign out_quo   = quo_r;
  assign out_tag   = tag_r;

endmodule

>>> hw/rtl/ptld_div_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptld_div_chain
// Row of division cells, one quotient bit per cell, most significant first.
// ----------------------------------------------------------------------------
module ptld_div_chain #(
  parameter int unsigned NW = 16,
  parameter int unsigned DW = 8,
  parameter int unsigned QW = 8,
  parameter int unsigned TW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_div,
  input  logic [TW-1:0] in_tag,
  output logic          out_valid,
  output logic [NW-1:0] out_rem,
  output logic [DW-1:0] out_div,
  output logic [QW-1:0] out_quo,
  output logic [TW-1:0] out_tag
);

  logic [QW:0]   valid_w;
  logic [NW-1:0] rem_w [QW+1];
  logic [DW-1:0] div_w [QW+1];
  logic [QW-1:0] quo_w [QW+1];
  logic [TW-1:0] tag_w [QW+1];

  // Head of the row.
  assign valid_w[0] = in_valid;
  assign rem_w[0]   = in_num;
  assign div_w[0]   = in_div;
  assign quo_w[0]   = '0;
  assign tag_w[0]   = in_tag;

  // Cell i settles quotient bit QW-1-i.
  for (genvar i = 0; i < QW; i++) begin : g_cell
    ptld_div_cell #(
      .NW(NW), .DW(DW), .QW(QW), .TW(TW), .K(QW - 1 - i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (valid_w[i]),
      .in_rem   (rem_w[i]),
      .in_div   (div_w[i]),
      .in_quo   (quo_w[i]),
      .in_tag   (tag_w[i]),
      .out_valid(valid_w[i+1]),
      .out_rem  (rem_w[i+1]),
      .out_div  (div_w[i+1]),
      .out_quo  (quo_w[i+1]),
      .out_tag  (tag_w[i+1])
    );
  end

  assign out_valid = valid_w[QW];
  assign out_rem   = rem_w[QW];
  assign out_div   = div_w[QW];
  assign out_quo   = quo_w[QW];
  assign out_tag   = tag_w[QW];

endmodule

>>> hw/rtl/ptld_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptld_sqrt_cell
// One digit-recurrence square root step: resolves root bit K.
// ----------------------------------------------------------------------------
module ptld_sqrt_cell #(
  parameter int unsigned XW = 17,
  parameter int unsigned RW = 9,
  parameter int unsigned TW = 1,
  parameter int unsigned K  = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [XW-1:0] in_rem,
  input  logic [RW-1:0] in_root,
  input  logic [TW-1:0] in_tag,
  output logic          out_valid,
  output logic [XW-1:0] out_rem,
  output logic [RW-1:0] out_root,
  output logic [TW-1:0] out_tag
);

  localparam int unsigned CW = (2 * RW > XW) ? 2 * RW : XW;

  logic [CW-1:0] rem_ext;
  logic [CW-1:0] trial;
  logic          fits;
  logic [XW-1:0] rem_nxt;
  logic [RW-1:0] root_nxt;
  logic          valid_r;
  logic [XW-1:0] rem_r;
  logic [RW-1:0] root_r;
  logic [TW-1:0] tag_r;

  // Setting bit K adds 2*root*2^K + 2^2K to the square; the two terms never overlap.
  assign rem_ext  = CW'(in_rem);
  assign trial    = (CW'(in_root) << (K + 1)) | (CW'(1) << (2 * K));
  assign fits     = rem_ext >= trial;
  assign rem_nxt  = fits ? XW'(rem_ext - trial) : in_rem;
  assign root_nxt = in_root | (RW'(fits) << K);

  // Beat valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  // Payload handed on to the next cell.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      tag_r  <= in_tag;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_root  = root_r;
  assign out_tag   = tag_r;

endmodule

>>> hw/rtl/ptld_sqrt_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptld_sqrt_chain
// Row of square root cells giving the floor of the root, one bit per cell.
// ----------------------------------------------------------------------------
module ptld_sqrt_chain #(
  parameter int unsigned XW = 17,
  parameter int unsigned RW = 9,
  parameter int unsigned TW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [XW-1:0] in_rad,
  input  logic [TW-1:0] in_tag,
  output logic          out_valid,
  output logic [XW-1:0] out_rem,
  output logic [RW-1:0] out_root,
  output logic [TW-1:0] out_tag
);

  logic [RW:0]   valid_w;
  logic [XW-1:0] rem_w  [RW+1];
  logic [RW-1:0] root_w [RW+1];
  logic [TW-1:0] tag_w  [RW+1];

  // Head of the row.
  assign valid_w[0] = in_valid;
  assign rem_w[0]   = in_rad;
  assign root_w[0]  = '0;
  assign tag_w[0]   = in_tag;

  // Cell i settles root bit RW-1-i.
  for (genvar i = 0; i < RW; i++) begin : g_cell
    ptld_sqrt_cell #(
      .XW(XW), .RW(RW), .TW(TW), .K(RW - 1 - i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (valid_w[i]),
      .in_rem   (rem_w[i]),
      .in_root  (root_w[i]),
      .in_tag   (tag_w[i]),
      .out_valid(valid_w[i+1]),
      .out_rem  (rem_w[i+1]),
      .out_root (root_w[i+1]),
      .out_tag  (tag_w[i+1])
    );
  end

  assign out_valid = valid_w[RW];
  assign out_rem   = rem_w[RW];
  assign out_root  = root_w[RW];
  assign out_tag   = tag_w[RW];

endmodule

>>> hw/rtl/point_to_line_distance_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_to_line_distance_core
// Perpendicular foot and Euclidean distance of a point to a configured line.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake            Payload
//   cfg      in         cfg_we               cfg_index, cfg_wdata
//   in       in         in_valid / in_ready  in_point_x, in_point_y
//   out      out        out_valid/out_ready  out_distance, out_foot_x, out_foot_y,
//                                            out_line_valid
//
// One beat per cycle in and out while the skid register is empty. The path has five front
// stages (differences, products, sums, partial products, reassembly), a row of
// 2*COORD_BITS+1 divide cells, COORD_BITS+1 square root cells and the output
// register. Reset is synchronous and resets only the valid bits and the line registers.
// When out_ready is held low a skid register takes one more beat and in_ready
// falls in the following cycle; the whole row of cells then holds.
// ----------------------------------------------------------------------------
module point_to_line_distance_core #(
  parameter int unsigned COORD_BITS = ptld_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ptld_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]          cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [COORD_BITS-1:0]   in_point_x,
  input  logic signed [COORD_BITS-1:0]   in_point_y,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [COORD_BITS:0]            out_distance,
  output logic signed [COORD_BITS-1:0]   out_foot_x,
  output logic signed [COORD_BITS-1:0]   out_foot_y,
  output logic                           out_line_valid
);

  import ptld_pkg::*;

  localparam int unsigned CB     = COORD_BITS;
  localparam int unsigned W1     = CB + 1;           // differences
  localparam int unsigned PW     = 2 * CB + 2;       // signed products
  localparam int unsigned DEN_W  = 2 * CB + 1;       // squared length
  localparam int unsigned MAG_W  = 2 * CB + 1;       // |dot|, |cross|
  localparam int unsigned LO_W   = CB + 1;
  localparam int unsigned NX_W   = 3 * CB + 1;       // |d| * |dot|
  localparam int unsigned SQ_W   = 2 * MAG_W;        // cross squared
  localparam int unsigned QO_W   = CB + 1;           // foot offset quotient
  localparam int unsigned QD_W   = 2 * CB + 1;       // squared distance
  localparam int unsigned DLY    = QD_W - QO_W;
  localparam int unsigned DIST_W = CB + 1;
  localparam int unsigned OFF_W  = CB + 2;
  localparam int unsigned SUM_W  = CB + 3;
  localparam int unsigned TAG_W  = 2 * CB + 1;
  localparam int unsigned RES_W  = DIST_W + TAG_W;

  // Foot coordinate: base plus the floored signed offset, saturated.
  function automatic logic [CB-1:0] foot_of(input logic [QO_W-1:0] quo,
                                            input logic rem_nz,
                                            input logic neg,
                                            input logic signed [CB-1:0] base);
    logic [OFF_W-1:0]        mag;
    logic signed [OFF_W-1:0] off;
    logic signed [SUM_W-1:0] sum;
    mag = OFF_W'(quo) + OFF_W'(rem_nz);
    off = neg ? -$signed(mag) : $signed(OFF_W'(quo));
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum[SUM_W-1:CB-1] == '0 || sum[SUM_W-1:CB-1] == '1) begin
      return sum[CB-1:0];
    end else if (sum[SUM_W-1]) begin
      return {1'b1, {(CB-1){1'b0}}};
    end else begin
      return {1'b0, {(CB-1){1'b1}}};
    end
  endfunction

  logic signed [CB-1:0] line_ax_r, line_ay_r, line_bx_r, line_by_r;
  logic                 en;
  logic                 degen;

  logic                 v1_r, v2_r, v3_r, v4_r, v5_r;
  logic signed [W1-1:0] dx_r, dy_r, ex_r, ey_r;
  logic                 dg1_r;
  logic signed [PW-1:0] pdd_r, pyy_r, pxe_r, pye_r, pxc_r, pyc_r, pee_r, pff_r;
  logic signed [W1-1:0] dx2_r, dy2_r;
  logic                 dg2_r;
  logic signed [PW-1:0] den_sum, sq_sum;
  logic [DEN_W-1:0]     den3_r, sq3_r;
  logic signed [PW-1:0] num3_r, crs3_r;
  logic signed [W1-1:0] dx3_r, dy3_r;
  logic                 dg3_r;
  logic signed [PW-1:0] num_abs, crs_abs;
  logic signed [W1-1:0] dx_abs, dy_abs;
  logic [MAG_W-1:0]     num_mag, crs_mag;
  logic [2*CB:0]        mxl_r, myl_r, chl_r;
  logic [2*CB-1:0]      mxh_r, myh_r, chh_r;
  logic [2*CB+1:0]      cll_r;
  logic                 sx4_r, sy4_r, dg4_r;
  logic [DEN_W-1:0]     den4_r, sq4_r;
  logic [NX_W-1:0]      nx5_r, ny5_r;
  logic [SQ_W-1:0]      c2_sum, dn5_r;
  logic [DEN_W-1:0]     den5_r;
  logic                 sx5_r, sy5_r, dg5_r;

  logic                 dc_valid;
  logic [NX_W-1:0]      xc_rem, yc_rem;
  logic [QO_W-1:0]      xc_quo, yc_quo;
  logic                 xc_tag, yc_tag, dc_tag;
  logic [QD_W-1:0]      dc_quo;
  logic [2*CB-1:0]      foot_w;
  logic [2*CB-1:0]      dly_r [DLY];

  logic                 sq_valid;
  logic [DIST_W-1:0]    sq_root;
  logic [TAG_W-1:0]     sq_tag;
  logic [RES_W-1:0]     res_w;
  logic [RES_W-1:0]     out_res_r, skid_res_r;
  logic                 out_valid_r, skid_valid_r;
  logic                 take;

  // Line registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_ax_r <= '0;
      line_ay_r <= '0;
      line_bx_r <= CB'(1) << FRAC_BITS;
      line_by_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LINE_AX: line_ax_r <= $signed(cfg_wdata);
        REG_LINE_AY: line_ay_r <= $signed(cfg_wdata);
        REG_LINE_BX: line_bx_r <= $signed(cfg_wdata);
        REG_LINE_BY: line_by_r <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // The whole row advances unless the skid register is occupied.
  assign en       = !skid_valid_r;
  assign in_ready = en;
  assign degen    = (line_ax_r == line_bx_r) && (line_ay_r == line_by_r);

  // Front valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // Stage 1: direction and offset of the point; a degenerate line measures from the origin.
  always_ff @(posedge clk) begin
    if (en) begin
      dg1_r <= degen;
      dx_r  <= degen ? '0 : W1'(line_bx_r) - W1'(line_ax_r);
      dy_r  <= degen ? '0 : W1'(line_by_r) - W1'(line_ay_r);
      ex_r  <= degen ? W1'(in_point_x) : W1'(in_point_x) - W1'(line_ax_r);
      ey_r  <= degen ? W1'(in_point_y) : W1'(in_point_y) - W1'(line_ay_r);
    end
  end

  // Stage 2: the products for squared length, dot and cross product, and the point's squared offset.
  always_ff @(posedge clk) begin
    if (en) begin
      pdd_r <= dx_r * dx_r;
      pyy_r <= dy_r * dy_r;
      pxe_r <= dx_r * ex_r;
      pye_r <= dy_r * ey_r;
      pxc_r <= dx_r * ey_r;
      pyc_r <= dy_r * ex_r;
      pee_r <= ex_r * ex_r;
      pff_r <= ey_r * ey_r;
      dx2_r <= dx_r;
      dy2_r <= dy_r;
      dg2_r <= dg1_r;
    end
  end

  // Stage 3: squared length, dot and cross product, and the point's squared offset.
  assign den_sum = pdd_r + pyy_r;
  assign sq_sum  = pee_r + pff_r;

  always_ff @(posedge clk) begin
    if (en) begin
      den3_r <= dg2_r ? DEN_W'(1) : den_sum[DEN_W-1:0];
      sq3_r  <= sq_sum[DEN_W-1:0];
      num3_r <= pxe_r + pye_r;
      crs3_r <= pxc_r - pyc_r;
      dx3_r  <= dx2_r;
      dy3_r  <= dy2_r;
      dg3_r  <= dg2_r;
    end
  end

  // Stage 4: magnitudes and split partial products.
  assign num_abs = num3_r[PW-1] ? -num3_r : num3_r;
  assign crs_abs = crs3_r[PW-1] ? -crs3_r : crs3_r;
  assign dx_abs  = dx3_r[W1-1] ? -dx3_r : dx3_r;
  assign dy_abs  = dy3_r[W1-1] ? -dy3_r : dy3_r;
  assign num_mag = num_abs[MAG_W-1:0];
  assign crs_mag = crs_abs[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      mxl_r  <= dx_abs[CB-1:0] * num_mag[LO_W-1:0];
      mxh_r  <= dx_abs[CB-1:0] * num_mag[MAG_W-1:LO_W];
      myl_r  <= dy_abs[CB-1:0] * num_mag[LO_W-1:0];
      myh_r  <= dy_abs[CB-1:0] * num_mag[MAG_W-1:LO_W];
      chh_r  <= crs_mag[MAG_W-1:LO_W] * crs_mag[MAG_W-1:LO_W];
      chl_r  <= crs_mag[MAG_W-1:LO_W] * crs_mag[LO_W-1:0];
      cll_r  <= crs_mag[LO_W-1:0] * crs_mag[LO_W-1:0];
      sx4_r  <= dx3_r[W1-1] ^ num3_r[PW-1];
      sy4_r  <= dy3_r[W1-1] ^ num3_r[PW-1];
      den4_r <= den3_r;
      sq4_r  <= sq3_r;
      dg4_r  <= dg3_r;
    end
  end

  // Stage 5: reassemble the wide products.
  assign c2_sum = (SQ_W'(chh_r) << (2 * LO_W)) + (SQ_W'(chl_r) << (LO_W + 1)) + SQ_W'(cll_r);

  always_ff @(posedge clk) begin
    if (en) begin
      nx5_r  <= (NX_W'(mxh_r) << LO_W) + NX_W'(mxl_r);
      ny5_r  <= (NX_W'(myh_r) << LO_W) + NX_W'(myl_r);
      dn5_r  <= dg4_r ? SQ_W'(sq4_r) : c2_sum;
      den5_r <= den4_r;
      sx5_r  <= sx4_r;
      sy5_r  <= sy4_r;
      dg5_r  <= dg4_r;
    end
  end

  // Foot offsets along x and y.
  ptld_div_chain #(.NW(NX_W), .DW(DEN_W), .QW(QO_W), .TW(1)) u_div_x (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v5_r), .in_num(nx5_r), .in_div(den5_r), .in_tag(sx5_r),
    .out_valid(), .out_rem(xc_rem), .out_div(), .out_quo(xc_quo), .out_tag(xc_tag)
  );

  ptld_div_chain #(.NW(NX_W), .DW(DEN_W), .QW(QO_W), .TW(1)) u_div_y (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v5_r), .in_num(ny5_r), .in_div(den5_r), .in_tag(sy5_r),
    .out_valid(), .out_rem(yc_rem), .out_div(), .out_quo(yc_quo), .out_tag(yc_tag)
  );

  // Squared distance: cross squared over squared length.
  ptld_div_chain #(.NW(SQ_W), .DW(DEN_W), .QW(QD_W), .TW(1)) u_div_d (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v5_r), .in_num(dn5_r), .in_div(den5_r), .in_tag(dg5_r),
    .out_valid(dc_valid), .out_rem(), .out_div(), .out_quo(dc_quo), .out_tag(dc_tag)
  );

  // Finished foot coordinates wait in a shift line for the distance divide.
  assign foot_w = {foot_of(xc_quo, |xc_rem, xc_tag, line_ax_r),
                   foot_of(yc_quo, |yc_rem, yc_tag, line_ay_r)};

  always_ff @(posedge clk) begin
    if (en) begin
      dly_r[0] <= foot_w;
      for (int i = 1; i < DLY; i++) begin
        dly_r[i] <= dly_r[i-1];
      end
    end
  end

  // Distance: floor of the square root.
  ptld_sqrt_chain #(.XW(QD_W), .RW(DIST_W), .TW(TAG_W)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(dc_valid), .in_rad(dc_quo), .in_tag({dly_r[DLY-1], dc_tag}),
    .out_valid(sq_valid), .out_rem(), .out_root(sq_root), .out_tag(sq_tag)
  );

  // Result beat; a degenerate line reports the origin as its foot.
  assign res_w = {sq_root,
                  sq_tag[0] ? {(2*CB){1'b0}} : sq_tag[TAG_W-1:1],
                  !sq_tag[0]};

  // Output register with one skid entry behind it.
  assign take = out_ready || !out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (take) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= sq_valid;
      end
    end else if (en && sq_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_res_r <= skid_valid_r ? skid_res_r : res_w;
    end else if (en) begin
      skid_res_r <= res_w;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_distance   = out_res_r[RES_W-1:TAG_W];
  assign out_foot_x     = $signed(out_res_r[TAG_W-1:CB+1]);
  assign out_foot_y     = $signed(out_res_r[CB:1]);
  assign out_line_valid = out_res_r[0];

endmodule

>>> hw/rtl/ptld_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptld_checker
// Port-level checks on the point-to-line distance core, bound to the top.
// ----------------------------------------------------------------------------
`include "point_to_line_distance_core_assert.svh"

module ptld_port_checker #(
  parameter int unsigned COORD_BITS = ptld_pkg::COORD_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [COORD_BITS:0]   out_distance,
  input logic [COORD_BITS-1:0] out_foot_x,
  input logic [COORD_BITS-1:0] out_foot_y,
  input logic                  out_line_valid
);

  // A stalled result beat stays put.
  `PTLD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_distance) && $stable(out_foot_x) && $stable(out_foot_y) && $stable(out_line_valid), "result beat changed while stalled")

  // A degenerate line reports its foot at the origin.
  `PTLD_ASSERT_IMPL(a_degen_foot, out_valid && !out_line_valid, out_foot_x == '0 && out_foot_y == '0, "degenerate line with non-zero foot")

  // Distance from the origin of an in-range point needs no top bit.
  `PTLD_ASSERT_IMPL(a_degen_dist, out_valid && !out_line_valid, !out_distance[COORD_BITS], "degenerate distance out of range")

  // Input back-pressure only follows a stalled result.
  `PTLD_ASSERT_IMPL(a_ready_cause, !in_ready, $past(out_valid && !out_ready), "in_ready low without an output stall")

endmodule

bind point_to_line_distance_core ptld_port_checker #(.COORD_BITS(COORD_BITS)) u_ptld_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_distance  (out_distance),
  .out_foot_x    (out_foot_x),
  .out_foot_y    (out_foot_y),
  .out_line_valid(out_line_valid)
);

>>> test/ptld_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptld_checker
// Watches the register port and both channels of the point-to-line distance
// core. It projects every accepted point onto its own copy of the line and
// compares each result beat, field by field, with the oldest projection.
// ----------------------------------------------------------------------------
module ptld_checker #(
  parameter int unsigned CB = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ptld_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [CB-1:0]                 cfg_wdata,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic signed [CB-1:0]          in_point_x,
  input  logic signed [CB-1:0]          in_point_y,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [CB:0]                   out_distance,
  input  logic signed [CB-1:0]          out_foot_x,
  input  logic signed [CB-1:0]          out_foot_y,
  input  logic                          out_line_valid,
  output int unsigned                   errors,
  output int unsigned                   waiting,
  output int unsigned                   checked
);

  import ptld_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic [CB:0]          distance;
    logic signed [CB-1:0] foot_x;
    logic signed [CB-1:0] foot_y;
    logic                 line_valid;
  } foot_t;

  // Copy of the line registers, reset to the unit segment along x.
  logic signed [CB-1:0] line_ax, line_ay, line_bx, line_by;
  foot_t foot_queue[$];

  localparam wide_t COORD_MAX = (wide_t'(1) <<< (CB - 1)) - 1;
  localparam wide_t COORD_MIN = -(wide_t'(1) <<< (CB - 1));

  function automatic wide_t floor_quot(wide_t n, wide_t d);
    wide_t q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  function automatic wide_t root_down(wide_t x);
    wide_t r, t;
    r = 0;
    for (int b = 40; b >= 0; b--) begin
      t = r | (wide_t'(1) <<< b);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  function automatic logic signed [CB-1:0] clamp(wide_t v);
    if (v > COORD_MAX) return CB'(COORD_MAX);
    if (v < COORD_MIN) return CB'(COORD_MIN);
    return CB'(v);
  endfunction

  // Exact projection of a point onto the line through A and B.
  function automatic foot_t project_point(logic signed [CB-1:0] px,
                                          logic signed [CB-1:0] py);
    wide_t ax, ay, dx, dy, ex, ey, den, num, crs, wx, wy;
    foot_t f;
    ax = line_ax;
    ay = line_ay;
    dx = wide_t'(line_bx) - ax;
    dy = wide_t'(line_by) - ay;
    wx = px;
    wy = py;
    if (dx == 0 && dy == 0) begin
      // A coincides with B: distance from the origin, foot at the origin.
      f.distance   = (CB + 1)'(root_down(wx * wx + wy * wy));
      f.foot_x     = '0;
      f.foot_y     = '0;
      f.line_valid = 1'b0;
    end else begin
      ex  = wx - ax;
      ey  = wy - ay;
      den = dx * dx + dy * dy;
      num = dx * ex + dy * ey;
      crs = dx * ey - dy * ex;
      f.foot_x     = clamp(ax + floor_quot(dx * num, den));
      f.foot_y     = clamp(ay + floor_quot(dy * num, den));
      f.distance   = (CB + 1)'(root_down((crs * crs) / den));
      f.line_valid = 1'b1;
    end
    return f;
  endfunction

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch in %s: got %0h, expected %0h", $realtime, field, got, want);
    errors++;
  endtask

  task automatic compare_field(string field, logic [63:0] got, logic [63:0] want);
    if (got !== want) report(field, got, want);
  endtask

  initial begin
    errors  = 0;
    checked = 0;
  end

  assign waiting = foot_queue.size();

  always @(posedge clk) begin
    foot_t want;
    if (!rst_n) begin
      line_ax <= '0;
      line_ay <= '0;
      line_bx <= CB'(1 << FRAC_BITS);
      line_by <= '0;
      foot_queue.delete();
    end else begin
      // Register writes; the user must write only while the block is idle, which it does not enforce.
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_LINE_AX: line_ax <= cfg_wdata;
          REG_LINE_AY: line_ay <= cfg_wdata;
          REG_LINE_BX: line_bx <= cfg_wdata;
          REG_LINE_BY: line_by <= cfg_wdata;
          default: ;
        endcase
      end
      // Result beat against the oldest projection.
      if (out_valid && out_ready) begin
        if (foot_queue.size() == 0) begin
          report("unexpected beat", {out_foot_x, out_foot_y}, 0);
        end else begin
          want = foot_queue.pop_front();
          compare_field("distance", out_distance, want.distance);
          compare_field("foot_x", out_foot_x, want.foot_x);
          compare_field("foot_y", out_foot_y, want.foot_y);
          compare_field("line_valid", out_line_valid, want.line_valid);
          checked++;
        end
      end
      if (in_valid && in_ready) foot_queue.push_back(project_point(in_point_x, in_point_y));
    end
  end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives points at the point-to-line distance core under a series of line
// settings (reset line, vertical, degenerate, extreme and random lines) with
// random gaps and back pressure, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
  import ptld_pkg::*;

  localparam int unsigned CB        = 24;
  localparam int unsigned LATENCY   = 3 * CB + 8;
  localparam int unsigned MAX_CYCLE = 600000;
  localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_LINE_AX;
  logic [CB-1:0]        cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [CB-1:0] in_point_x = '0;
  logic signed [CB-1:0] in_point_y = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [CB:0]          out_distance;
  logic signed [CB-1:0] out_foot_x, out_foot_y;
  logic                 out_line_valid;

  int unsigned errors, waiting, checked;
  int unsigned points_sent = 0;
  int unsigned settings_used = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  bit          quiet = 1'b0;
  bit          squeeze_done = 1'b0;
  logic signed [CB-1:0] cur_ax = '0, cur_ay = '0;

  point_to_line_distance_core #(.COORD_BITS(CB)) u_dut (.*);

  ptld_checker #(.CB(CB)) u_checker (.*);

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the cycle count.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLE) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: random stalls, and one long hold-off so that the core fills up.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!squeeze_done && points_sent >= 300) begin
      out_ready    <= 1'b0;
      stall_left   <= 400;
      squeeze_done <= 1'b1;
    end else begin
      if (quiet || $urandom_range(0, 99) < 70) begin
        out_ready <= 1'b1;
      end else begin
        out_ready  <= 1'b0;
        stall_left <= pick_gap();
      end
    end
  end

  // One point beat; valid stays high between back-to-back beats.
  task automatic send_point(logic signed [CB-1:0] x, logic signed [CB-1:0] y);
    int unsigned gap;
    bit taken;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_point_x <= x;
    in_point_y <= y;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    points_sent++;
  endtask

  // Rewrites the line once every expected beat is back and the core is empty.
  task automatic set_line(logic signed [CB-1:0] ax, logic signed [CB-1:0] ay,
                          logic signed [CB-1:0] bx, logic signed [CB-1:0] by);
    in_valid <= 1'b0;
    @(posedge clk);
    wait (waiting == 0);
    repeat (LATENCY + 8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_LINE_AX;
    cfg_wdata <= ax;
    @(posedge clk);
    cfg_index <= REG_LINE_AY;
    cfg_wdata <= ay;
    @(posedge clk);
    cfg_index <= REG_LINE_BX;
    cfg_wdata <= bx;
    @(posedge clk);
    cfg_index <= REG_LINE_BY;
    cfg_wdata <= by;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_ax = ax;
    cur_ay = ay;
    settings_used++;
  endtask

  // Corners and the origin of the coordinate range.
  task automatic send_corners();
    send_point(CMAX, CMAX);
    send_point(CMIN, CMIN);
    send_point(CMIN, CMAX);
    send_point(CMAX, CMIN);
    send_point('0, '0);
  endtask

  // Random points: full range, near the line's first point, or on the left and right edges.
  task automatic send_random(int unsigned count);
    int unsigned mode;
    logic signed [CB-1:0] x, y;
    for (int unsigned i = 0; i < count; i++) begin
      mode = $urandom_range(0, 9);
      if (mode < 4) begin
        x = CB'($urandom);
        y = CB'($urandom);
      end else if (mode < 8) begin
        x = cur_ax + CB'($signed($urandom_range(0, 8191)) - 4096);
        y = cur_ay + CB'($signed($urandom_range(0, 8191)) - 4096);
      end else begin
        x = $urandom_range(0, 1) ? CMAX : CMIN;
        y = $urandom_range(0, 1) ? CMAX : CB'($urandom_range(0, 3));
      end
      send_point(x, y);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset line along the x axis.
    settings_used = 1;
    send_corners();
    send_point(CB'(256), '0);
    send_point('1, '1);
    send_random(200);

    // Vertical line.
    set_line(CB'(100), CB'(-5000), CB'(100), CB'(7000));
    send_corners();
    send_point(CB'(100), CB'(123));
    quiet = 1'b1;
    send_random(200);
    quiet = 1'b0;

    // Coinciding points: no line at all.
    set_line(CB'(777), CB'(-777), CB'(777), CB'(-777));
    send_corners();
    send_random(150);

    // Diagonal across the whole range.
    set_line(CMIN, CMIN, CMAX, CMAX);
    send_corners();
    send_random(150);

    // Diagonal near the upper x limit; the foot runs out of range.
    set_line(CMAX - CB'(256), '0, CMAX, CB'(256));
    send_corners();
    send_point(CMAX, CMAX);
    send_random(150);

    // Horizontal line at the upper limit, and the shortest possible segment.
    set_line(CMIN, CMAX, CMAX, CMAX);
    send_random(100);
    set_line(CB'(-3), CB'(9), CB'(-2), CB'(9));
    send_random(100);

    // Random lines, half of them short segments.
    for (int k = 0; k < 4; k++) begin
      logic signed [CB-1:0] ax, ay;
      ax = CB'($urandom);
      ay = CB'($urandom);
      if (k < 2)
        set_line(ax, ay, ax + CB'($urandom_range(0, 600)), ay - CB'($urandom_range(0, 600)));
      else
        set_line(ax, ay, CB'($urandom), CB'($urandom));
      send_random(100);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    wait (waiting == 0);
    repeat (LATENCY + 20) @(posedge clk);

    $display("Sent %0d points under %0d line settings; %0d results checked.",
             points_sent, settings_used, checked);
    if (errors == 0 && waiting == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
